### sv/vfv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfv_pkg - shared types and constants for voxel face visibility
// Chunk geometry, command codes, direction order and the address bundle
// that travels from the neighbor address generator to the top level.
// ----------------------------------------------------------------------------
package vfv_pkg;

	// Chunk edge length; power of two so x, y, z are plain bit fields.
	localparam int EDGE_LEN    = 16;
	localparam int EDGE_BITS   = $clog2(EDGE_LEN);
	localparam int PLANE_BITS  = 2 * EDGE_BITS;
	localparam int CELL_BITS   = 3 * EDGE_BITS;
	localparam int PLANE_CELLS = EDGE_LEN * EDGE_LEN;
	localparam int CHUNK_CELLS = PLANE_CELLS * EDGE_LEN;
	localparam int NUM_DIRS    = 6;
	localparam int KIND_BITS_DEF = 8;

	// Width of the code-facing ports and of the extension used to fit them.
	localparam int KIND_PORT_BITS = 8;
	localparam int KIND_EXT_BITS  = 16;

	typedef enum logic [1:0] {
		CMD_LOAD_BLOCK  = 2'd0,
		CMD_LOAD_BORDER = 2'd1,
		CMD_QUERY       = 2'd2
	} cmd_t;

	// Configuration register indexes.
	localparam logic REG_NEIGHBOR_PRESENT = 1'b0;
	localparam logic REG_AIR_CODE         = 1'b1;

	// Direction and face order.
	localparam int DIR_PZ = 0;
	localparam int DIR_NZ = 1;
	localparam int DIR_PY = 2;
	localparam int DIR_NY = 3;
	localparam int DIR_NX = 4;
	localparam int DIR_PX = 5;

	typedef struct packed {
		logic [NUM_DIRS-1:0][CELL_BITS-1:0]  blk_addr;
		logic [NUM_DIRS-1:0][PLANE_BITS-1:0] brd_addr;
		logic [NUM_DIRS-1:0]                 on_edge;
	} nbr_addr_t;

endpackage : vfv_pkg
`default_nettype wire

### sv/vfv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfv_ram - simple dual-port synchronous memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vfv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule : vfv_ram
`default_nettype wire

### sv/vfv_nbr_addr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfv_nbr_addr - neighbor address generator
// Split a block index into x, y, z and form the six neighbor block
// addresses, the six border plane cells and the chunk edge flags.
// ----------------------------------------------------------------------------
module vfv_nbr_addr (
	input  wire logic [vfv_pkg::CELL_BITS-1:0] block_index,
	output      vfv_pkg::nbr_addr_t            nbr
);
	import vfv_pkg::*;

	localparam logic [EDGE_BITS-1:0] LAST = EDGE_BITS'(EDGE_LEN - 1);
	localparam logic [EDGE_BITS-1:0] ONE  = EDGE_BITS'(1);

	logic [EDGE_BITS-1:0] x, y, z;

	assign x = block_index[EDGE_BITS-1:0];
	assign y = block_index[2*EDGE_BITS-1:EDGE_BITS];
	assign z = block_index[3*EDGE_BITS-1:2*EDGE_BITS];

	always_comb begin
		// Wrapped addresses are harmless: an edge face reads the border bank.
		nbr.blk_addr[DIR_PZ] = {z + ONE, y, x};
		nbr.blk_addr[DIR_NZ] = {z - ONE, y, x};
		nbr.blk_addr[DIR_PY] = {z, y + ONE, x};
		nbr.blk_addr[DIR_NY] = {z, y - ONE, x};
		nbr.blk_addr[DIR_NX] = {z, y, x - ONE};
		nbr.blk_addr[DIR_PX] = {z, y, x + ONE};

		// Border cell is a*EDGE_LEN + b with (a,b) per plane orientation.
		nbr.brd_addr[DIR_PZ] = {x, y};
		nbr.brd_addr[DIR_NZ] = {x, y};
		nbr.brd_addr[DIR_PY] = {x, z};
		nbr.brd_addr[DIR_NY] = {x, z};
		nbr.brd_addr[DIR_NX] = {y, z};
		nbr.brd_addr[DIR_PX] = {y, z};

		nbr.on_edge[DIR_PZ] = (z == LAST);
		nbr.on_edge[DIR_NZ] = (z == '0);
		nbr.on_edge[DIR_PY] = (y == LAST);
		nbr.on_edge[DIR_NY] = (y == '0);
		nbr.on_edge[DIR_NX] = (x == '0);
		nbr.on_edge[DIR_PX] = (x == LAST);
	end

endmodule : vfv_nbr_addr
`default_nettype wire

### sv/voxel_face_visibility_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_face_visibility_top - face culling for one cubic chunk of blocks
// Holds block codes and neighbor border air flags; answers face queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command per beat: load
//   a block code, load a neighbor border air flag, or query a block. Only
//   a query yields an output beat (out_valid / out_stall) with the block's
//   position, stored code, solid flag and six-bit visible face mask.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) sets the
//   neighbor present mask and the air code; write it while the block idles.
//   cfg_ready is always high.
// Timing:
//   One beat per cycle while in_stall is low. An accepted query is held in
//   the stage one registers, then in the output register. Every query reads
//   seven block codes and six border flags together; the code store is
//   copied into seven banks (self plus six neighbors), the border flags into
//   one bank per direction, so each bank serves one read port per cycle. A
//   load written at one edge is seen by a query accepted at the next.
// Reset:
//   Clears the pipeline valids and both registers. The memories are not
//   cleared; a query must not touch entries that were never loaded.
// Backpressure:
//   When out_stall holds a result and a second query waits in stage one,
//   in_stall rises; otherwise the input keeps flowing.
// ----------------------------------------------------------------------------
module voxel_face_visibility_top #(
	parameter int KIND_BITS = vfv_pkg::KIND_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input channel
	input  wire logic                                in_valid,
	output      logic                                in_stall,
	input  wire logic [1:0]                          cmd,
	input  wire logic [vfv_pkg::CELL_BITS-1:0]       block_index,
	input  wire logic [vfv_pkg::KIND_PORT_BITS-1:0]  block_kind,
	input  wire logic [2:0]                          border_face,
	input  wire logic [vfv_pkg::PLANE_BITS-1:0]      border_cell,
	input  wire logic                                border_is_air,
	// output channel
	output      logic                                out_valid,
	input  wire logic                                out_stall,
	output      logic [vfv_pkg::EDGE_BITS-1:0]       pos_x,
	output      logic [vfv_pkg::EDGE_BITS-1:0]       pos_y,
	output      logic [vfv_pkg::EDGE_BITS-1:0]       pos_z,
	output      logic [vfv_pkg::KIND_PORT_BITS-1:0]  kind_out,
	output      logic [vfv_pkg::NUM_DIRS-1:0]        visible_faces,
	output      logic                                is_solid,
	// configuration channel
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic                                cfg_index,
	input  wire logic [vfv_pkg::KIND_PORT_BITS-1:0]  cfg_data
);
	import vfv_pkg::*;

	localparam int NUM_BANKS = NUM_DIRS + 1;

	// ---- configuration registers ----
	logic [NUM_DIRS-1:0]       present_q;
	logic [KIND_PORT_BITS-1:0] air_code_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= '0;
			air_code_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_NEIGHBOR_PRESENT: present_q  <= cfg_data[NUM_DIRS-1:0];
				REG_AIR_CODE:         air_code_q <= cfg_data;
				default:              ;
			endcase
		end
	end

	// ---- handshake and pipeline control ----
	logic in_accept;
	logic s1_move;
	logic s1_valid_q;
	logic is_query;

	assign s1_move   = !out_valid || !out_stall;
	assign in_stall  = s1_valid_q && !s1_move;
	assign in_accept = in_valid && !in_stall;
	assign is_query  = (cmd_t'(cmd) == CMD_QUERY);

	// ---- address generation ----
	nbr_addr_t nbr;

	vfv_nbr_addr u_nbr_addr (
		.block_index (block_index),
		.nbr         (nbr)
	);

	// ---- block code banks: bank 0 reads self, bank d+1 reads neighbor d ----
	logic [KIND_EXT_BITS-1:0]  kind_ext;
	logic [KIND_BITS-1:0]      kind_wr;
	logic                      blk_we;
	logic [KIND_BITS-1:0]      code_rd [NUM_BANKS];
	logic [CELL_BITS-1:0]      bank_raddr [NUM_BANKS];

	assign kind_ext = KIND_EXT_BITS'(block_kind);
	assign kind_wr  = kind_ext[KIND_BITS-1:0];
	// Every index fits the chunk, so no range check is needed on loads.
	assign blk_we   = in_accept && (cmd_t'(cmd) == CMD_LOAD_BLOCK);

	assign bank_raddr[0] = block_index;

	for (genvar d = 0; d < NUM_DIRS; d++) begin : g_raddr
		assign bank_raddr[d+1] = nbr.blk_addr[d];
	end

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_blk_bank
		vfv_ram #(
			.WIDTH (KIND_BITS),
			.DEPTH (CHUNK_CELLS)
		) u_blk_ram (
			.clk   (clk),
			.we    (blk_we),
			.waddr (block_index),
			.wdata (kind_wr),
			.re    (in_accept),
			.raddr (bank_raddr[b]),
			.rdata (code_rd[b])
		);
	end

	// ---- border air flag banks, one per direction ----
	logic [NUM_DIRS-1:0] brd_rd;

	for (genvar d = 0; d < NUM_DIRS; d++) begin : g_brd_bank
		logic brd_we;

		// Faces above five match no bank and drop; every cell fits the plane.
		assign brd_we = in_accept && (cmd_t'(cmd) == CMD_LOAD_BORDER)
			&& (border_face == 3'(d));

		vfv_ram #(
			.WIDTH (1),
			.DEPTH (PLANE_CELLS)
		) u_brd_ram (
			.clk   (clk),
			.we    (brd_we),
			.waddr (border_cell),
			.wdata (border_is_air),
			.re    (in_accept),
			.raddr (nbr.brd_addr[d]),
			.rdata (brd_rd[d])
		);
	end

	// ---- stage 1: position and edge flags beside the memory read ----
	logic [CELL_BITS-1:0] idx_s1;
	logic [NUM_DIRS-1:0]  on_edge_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!s1_valid_q || s1_move) begin
			s1_valid_q <= in_accept && is_query;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			idx_s1     <= block_index;
			on_edge_s1 <= nbr.on_edge;
		end
	end

	// ---- stage 1 evaluation: compare codes against air, pick edge source ----
	logic [KIND_EXT_BITS-1:0] air_ext;
	logic [KIND_BITS-1:0]     air_k;
	logic [KIND_EXT_BITS-1:0] self_ext;
	logic                     solid_s1;
	logic [NUM_DIRS-1:0]      nbr_air;
	logic [NUM_DIRS-1:0]      edge_air;
	logic [NUM_DIRS-1:0]      mask_s1;

	assign air_ext  = KIND_EXT_BITS'(air_code_q);
	assign air_k    = air_ext[KIND_BITS-1:0];
	assign self_ext = KIND_EXT_BITS'(code_rd[0]);
	assign solid_s1 = (code_rd[0] != air_k);

	always_comb begin
		for (int d = 0; d < NUM_DIRS; d++) begin
			nbr_air[d]  = (code_rd[d+1] == air_k);
			// Absent neighbor chunk counts as air.
			edge_air[d] = !present_q[d] || brd_rd[d];
			mask_s1[d]  = solid_s1 && (on_edge_s1[d] ? edge_air[d] : nbr_air[d]);
		end
	end

	// ---- output register ----
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && s1_valid_q) begin
			pos_x         <= idx_s1[EDGE_BITS-1:0];
			pos_y         <= idx_s1[2*EDGE_BITS-1:EDGE_BITS];
			pos_z         <= idx_s1[3*EDGE_BITS-1:2*EDGE_BITS];
			kind_out      <= self_ext[KIND_PORT_BITS-1:0];
			visible_faces <= mask_s1;
			is_solid      <= solid_s1;
		end
	end

	assign out_valid = out_valid_q;

	// ---- assertions ----
	// A load never reaches stage one.
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && !is_query |=> !s1_valid_q)
		else $error("load produced a stage one entry");

	// An air block shows no faces.
	a_air_empty_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_solid |-> visible_faces == '0)
		else $error("air block reported visible faces");

	// Input backs up only with both stages full and the output stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q && out_valid_q && out_stall)
		else $error("input stalled without a full pipeline");

	// A held stage one entry keeps its index while the output is stalled.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_move |=> s1_valid_q && $stable(idx_s1))
		else $error("stage one entry changed while held");

endmodule : voxel_face_visibility_top
`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench - voxel face visibility, self-checking
// Loads block codes and border air flags, queries blocks, and compares each
// result beat with an in-bench prediction of position, code, solid flag and
// face mask. The run steps through several neighbor masks and air codes
// under varied sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	import vfv_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int NUM_PHASES  = 4;
	localparam int PHASE_ITEMS = 310;

	// The input port carries four codes; the package names only three.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [EDGE_BITS-1:0] COORD_MAX = EDGE_BITS'(EDGE_LEN - 1);
	localparam logic [CELL_BITS-1:0] STEP_Y    = CELL_BITS'(EDGE_LEN);
	localparam logic [CELL_BITS-1:0] STEP_Z    = CELL_BITS'(PLANE_CELLS);

	// How build_cell fills the six cells around a center block.
	typedef enum {NBR_RANDOM, NBR_AIR, NBR_SOLID} nbr_style_t;

	typedef struct packed {
		logic [EDGE_BITS-1:0]      px;
		logic [EDGE_BITS-1:0]      py;
		logic [EDGE_BITS-1:0]      pz;
		logic [KIND_PORT_BITS-1:0] kind;
		logic [NUM_DIRS-1:0]       faces;
		logic                      solid;
	} face_result_t;

	// Shadow of the chunk, its border planes and its registers, plus the queue
	// of face results still owed by the block.
	class face_scoreboard;
		logic [KIND_PORT_BITS-1:0] code_store [CHUNK_CELLS];
		bit                        code_known [CHUNK_CELLS];
		bit                        border_air [NUM_DIRS*PLANE_CELLS];
		bit                        border_known [NUM_DIRS*PLANE_CELLS];
		logic [NUM_DIRS-1:0]       nbr_present;
		logic [KIND_PORT_BITS-1:0] air_code;
		face_result_t              owed_q [$];
		int                        mismatches;
		int                        checked;
		int                        solid_seen;

		function new();
			nbr_present = '0;
			air_code    = '0;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void set_register(logic index, logic [KIND_PORT_BITS-1:0] data);
			if (index == REG_NEIGHBOR_PRESENT)
				nbr_present = data[NUM_DIRS-1:0];
			else
				air_code = data;
		endfunction

		// Locate what lies beyond face dir of block idx: another block inside the
		// chunk, or a cell of that direction's border plane.
		function void neighbor(input logic [CELL_BITS-1:0] idx, input int dir,
				output bit on_edge, output logic [CELL_BITS-1:0] nidx,
				output logic [PLANE_BITS-1:0] plane_idx);
			logic [EDGE_BITS-1:0] x, y, z;
			x = idx[EDGE_BITS-1:0];
			y = idx[2*EDGE_BITS-1:EDGE_BITS];
			z = idx[CELL_BITS-1:2*EDGE_BITS];
			case (dir)
			DIR_PZ: begin
				on_edge = (z == COORD_MAX); nidx = idx + STEP_Z; plane_idx = {x, y};
			end
			DIR_NZ: begin
				on_edge = (z == '0);        nidx = idx - STEP_Z; plane_idx = {x, y};
			end
			DIR_PY: begin
				on_edge = (y == COORD_MAX); nidx = idx + STEP_Y; plane_idx = {x, z};
			end
			DIR_NY: begin
				on_edge = (y == '0);        nidx = idx - STEP_Y; plane_idx = {x, z};
			end
			DIR_NX: begin
				on_edge = (x == '0);        nidx = idx - 1'b1;   plane_idx = {y, z};
			end
			default: begin
				on_edge = (x == COORD_MAX); nidx = idx + 1'b1;   plane_idx = {y, z};
			end
			endcase
		endfunction

		// True once the block and everything beyond its six faces has been loaded.
		function bit can_query(logic [CELL_BITS-1:0] idx);
			bit                    ok;
			bit                    on_edge;
			logic [CELL_BITS-1:0]  nidx;
			logic [PLANE_BITS-1:0] plane_idx;
			int                    d;
			ok = code_known[idx];
			for (d = 0; d < NUM_DIRS; d++) begin
				neighbor(idx, d, on_edge, nidx, plane_idx);
				if (on_edge)
					ok &= border_known[d*PLANE_CELLS + plane_idx];
				else
					ok &= code_known[nidx];
			end
			return ok;
		endfunction

		// Apply one accepted input beat; a query adds the face result it owes.
		function void note_input(logic [1:0] op, logic [CELL_BITS-1:0] idx,
				logic [KIND_PORT_BITS-1:0] kind, logic [2:0] face,
				logic [PLANE_BITS-1:0] plane_idx, logic flag);
			face_result_t          r;
			bit                    on_edge;
			logic [CELL_BITS-1:0]  nidx;
			logic [PLANE_BITS-1:0] bcell;
			int                    d;
			case (op)
			CMD_LOAD_BLOCK: begin
				code_store[idx] = kind;
				code_known[idx] = 1'b1;
			end
			CMD_LOAD_BORDER: begin
				// Directions six and seven do not exist; drop the beat.
				if (face < NUM_DIRS) begin
					border_air[face*PLANE_CELLS + plane_idx]   = flag;
					border_known[face*PLANE_CELLS + plane_idx] = 1'b1;
				end
			end
			CMD_QUERY: begin
				r.px    = idx[EDGE_BITS-1:0];
				r.py    = idx[2*EDGE_BITS-1:EDGE_BITS];
				r.pz    = idx[CELL_BITS-1:2*EDGE_BITS];
				r.kind  = code_store[idx];
				r.solid = (code_store[idx] != air_code);
				r.faces = '0;
				// An air block shows no faces at all.
				if (r.solid) begin
					for (d = 0; d < NUM_DIRS; d++) begin
						neighbor(idx, d, on_edge, nidx, bcell);
						if (on_edge)
							r.faces[d] = !nbr_present[d] || border_air[d*PLANE_CELLS + bcell];
						else
							r.faces[d] = (code_store[nidx] == air_code);
					end
					solid_seen++;
				end
				owed_q = {owed_q, r};
			end
			default: ;
			endcase
		endfunction

		task report(string msg);
			mismatches++;
			$display("[%0t] check failed: %s", $time, msg);
		endtask

		task check_result(face_result_t got);
			face_result_t want;
			if (owed_q.size() == 0) begin
				report($sformatf("result for (%0d,%0d,%0d) with no query outstanding",
					got.px, got.py, got.pz));
			end else begin
				want = owed_q.pop_front();
				checked++;
				if (got !== want)
					report($sformatf({"got pos (%0d,%0d,%0d) kind %h faces %b solid %b, ",
						"want pos (%0d,%0d,%0d) kind %h faces %b solid %b"},
						got.px, got.py, got.pz, got.kind, got.faces, got.solid,
						want.px, want.py, want.pz, want.kind, want.faces, want.solid));
			end
		endtask
	endclass

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      in_valid      = 1'b0;
	logic                      in_stall;
	logic [1:0]                cmd           = '0;
	logic [CELL_BITS-1:0]      block_index   = '0;
	logic [KIND_PORT_BITS-1:0] block_kind    = '0;
	logic [2:0]                border_face   = '0;
	logic [PLANE_BITS-1:0]     border_cell   = '0;
	logic                      border_is_air = 1'b0;
	logic                      out_valid;
	logic                      out_stall     = 1'b0;
	logic [EDGE_BITS-1:0]      pos_x;
	logic [EDGE_BITS-1:0]      pos_y;
	logic [EDGE_BITS-1:0]      pos_z;
	logic [KIND_PORT_BITS-1:0] kind_out;
	logic [NUM_DIRS-1:0]       visible_faces;
	logic                      is_solid;
	logic                      cfg_valid     = 1'b0;
	logic                      cfg_ready;
	logic                      cfg_index     = 1'b0;
	logic [KIND_PORT_BITS-1:0] cfg_data      = '0;

	face_scoreboard       sb;
	int                   send_idle_pct = 0;
	int                   stall_pct     = 0;
	int                   phase_items;
	int                   beats_total;
	int                   cycle_count;
	logic [CELL_BITS-1:0] centers [$];

	voxel_face_visibility_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.block_index   (block_index),
		.block_kind    (block_kind),
		.border_face   (border_face),
		.border_cell   (border_cell),
		.border_is_air (border_is_air),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.kind_out      (kind_out),
		.visible_faces (visible_faces),
		.is_solid      (is_solid),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Receiver: stall at the rate the current phase asks for.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Check every result beat taken at this edge against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({pos_x, pos_y, pos_z, kind_out, visible_faces, is_solid});
	end

	// Drive one input beat, idling first at the phase's rate, and hold it until
	// the block takes it. Valid stays high on return so back-to-back beats flow.
	task automatic send_beat(logic [1:0] op, logic [CELL_BITS-1:0] idx,
			logic [KIND_PORT_BITS-1:0] kind, logic [2:0] face,
			logic [PLANE_BITS-1:0] plane_idx, logic flag);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= op;
		block_index   <= idx;
		block_kind    <= kind;
		border_face   <= face;
		border_cell   <= plane_idx;
		border_is_air <= flag;
		do begin
			@(posedge clk);
		end while (in_stall);
		sb.note_input(op, idx, kind, face, plane_idx, flag);
		beats_total++;
		// Beats the block drops do not count toward the phase's work.
		if (!(op == CMD_UNUSED || (op == CMD_LOAD_BORDER && face >= NUM_DIRS)))
			phase_items++;
	endtask

	// Unused fields of each beat carry random bits.
	task automatic send_block(logic [CELL_BITS-1:0] idx, logic [KIND_PORT_BITS-1:0] kind);
		send_beat(CMD_LOAD_BLOCK, idx, kind, 3'($urandom), PLANE_BITS'($urandom),
			1'($urandom));
	endtask

	task automatic send_border(logic [2:0] face, logic [PLANE_BITS-1:0] plane_idx,
			logic flag);
		send_beat(CMD_LOAD_BORDER, CELL_BITS'($urandom), KIND_PORT_BITS'($urandom),
			face, plane_idx, flag);
	endtask

	task automatic send_query(logic [CELL_BITS-1:0] idx);
		send_beat(CMD_QUERY, idx, KIND_PORT_BITS'($urandom), 3'($urandom),
			PLANE_BITS'($urandom), 1'($urandom));
	endtask

	// Lower valid and wait until every owed result has come back, then let the
	// two-stage pipeline settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(logic [NUM_DIRS-1:0] present, logic [KIND_PORT_BITS-1:0] air);
		logic [KIND_PORT_BITS-1:0] data;
		// Upper bits of the present mask write are don't-care; fill them randomly.
		data      = {2'($urandom), present};
		cfg_valid <= 1'b1;
		cfg_index <= REG_NEIGHBOR_PRESENT;
		cfg_data  <= data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		sb.set_register(REG_NEIGHBOR_PRESENT, data);
		cfg_index <= REG_AIR_CODE;
		cfg_data  <= air;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		sb.set_register(REG_AIR_CODE, air);
		cfg_valid <= 1'b0;
	endtask

	// Favor air and near-air codes so masks come out mixed.
	function automatic logic [KIND_PORT_BITS-1:0] pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return sb.air_code;
		if (r < 60)
			return ~sb.air_code;
		if (r < 75)
			return sb.air_code ^ (8'h01 << $urandom_range(7));
		return KIND_PORT_BITS'($urandom);
	endfunction

	// Lean toward the chunk faces so edge handling sees plenty of traffic.
	function automatic logic [CELL_BITS-1:0] random_center();
		logic [EDGE_BITS-1:0] c [3];
		foreach (c[i])
			c[i] = ($urandom_range(9) < 3) ? ($urandom_range(1) ? COORD_MAX : '0) :
				EDGE_BITS'($urandom);
		return {c[2], c[1], c[0]};
	endfunction

	// Load a block and all six things beyond its faces, then query it.
	task automatic build_cell(logic [CELL_BITS-1:0] idx, logic [KIND_PORT_BITS-1:0] self_kind,
			nbr_style_t style);
		bit                    on_edge;
		logic [CELL_BITS-1:0]  nidx;
		logic [PLANE_BITS-1:0] plane_idx;
		int                    d;
		send_block(idx, self_kind);
		for (d = 0; d < NUM_DIRS; d++) begin
			sb.neighbor(idx, d, on_edge, nidx, plane_idx);
			case (style)
			NBR_AIR: begin
				if (on_edge)
					send_border(3'(d), plane_idx, 1'b1);
				else
					send_block(nidx, sb.air_code);
			end
			NBR_SOLID: begin
				if (on_edge)
					send_border(3'(d), plane_idx, 1'b0);
				else
					send_block(nidx, ~sb.air_code);
			end
			default: begin
				if (on_edge)
					send_border(3'(d), plane_idx, 1'($urandom));
				else
					send_block(nidx, pick_kind());
			end
			endcase
		end
		send_query(idx);
		centers = {centers, idx};
	endtask

	// One random step: mostly build-and-query sequences, then re-queries of
	// known blocks, overwrites around them, and some noise.
	task automatic random_step();
		int                    r;
		logic [CELL_BITS-1:0]  idx;
		bit                    on_edge;
		logic [CELL_BITS-1:0]  nidx;
		logic [PLANE_BITS-1:0] plane_idx;
		int                    d;
		r = $urandom_range(99);
		if (r < 55 || centers.size() == 0) begin
			build_cell(random_center(), pick_kind(), NBR_RANDOM);
		end else if (r < 75) begin
			idx = CELL_BITS'($urandom);
			if (!sb.can_query(idx))
				idx = centers[$urandom_range(centers.size() - 1)];
			send_query(idx);
		end else if (r < 88) begin
			// Overwrite a known center, or a block or border cell next to it.
			idx = centers[$urandom_range(centers.size() - 1)];
			d   = $urandom_range(NUM_DIRS);
			if (d == NUM_DIRS) begin
				send_block(idx, pick_kind());
			end else begin
				sb.neighbor(idx, d, on_edge, nidx, plane_idx);
				if (on_edge)
					send_border(3'(d), plane_idx, 1'($urandom));
				else
					send_block(nidx, pick_kind());
			end
		end else begin
			case ($urandom_range(3))
			0: send_beat(CMD_UNUSED, CELL_BITS'($urandom), KIND_PORT_BITS'($urandom),
				3'($urandom), PLANE_BITS'($urandom), 1'($urandom));
			1: send_border(3'($urandom_range(7, NUM_DIRS)), PLANE_BITS'($urandom),
				1'($urandom));
			2: send_block(CELL_BITS'($urandom), KIND_PORT_BITS'($urandom));
			default: send_border(3'($urandom_range(NUM_DIRS - 1)), PLANE_BITS'($urandom),
				1'($urandom));
			endcase
		end
	endtask

	initial begin : stimulus
		int                        phase;
		bit                        paused;
		logic [NUM_DIRS-1:0]       present;
		logic [KIND_PORT_BITS-1:0] air;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: all neighbors present, code zero is air.
		write_config('1, '0);
		// Origin corner: every face borders air, three of them via border planes.
		build_cell('0, 8'hA5, NBR_AIR);
		// Far corner: buried on every side, border cells solid.
		build_cell('1, 8'hFF, NBR_SOLID);
		// Turn the far corner into air: empty mask, not solid.
		send_block('1, 8'h00);
		send_query('1);
		// Unused command and nonexistent border directions must be dropped.
		send_beat(CMD_UNUSED, '1, '1, '1, '1, 1'b1);
		send_border(3'd6, '0, 1'b0);
		send_border(3'd7, '1, 1'b0);
		send_query('0);
		drain_results();

		// Random part: one register setting and one idle pattern per phase.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
			0: begin present = '1; air = '0; send_idle_pct = 0; stall_pct = 0; end
			1: begin present = '0; air = '1; send_idle_pct = 71; stall_pct = 0; end
			2: begin
				present = NUM_DIRS'($urandom);
				air     = KIND_PORT_BITS'($urandom);
				send_idle_pct = 0;
				stall_pct     = 71;
			end
			default: begin
				present = NUM_DIRS'($urandom);
				air     = KIND_PORT_BITS'($urandom);
				send_idle_pct = 20;
				stall_pct     = 20;
			end
			endcase
			write_config(present, air);
			phase_items = 0;
			paused      = 1'b0;
			while (phase_items < PHASE_ITEMS) begin
				random_step();
				// Halfway through, hold the sender until the output side is empty.
				if (!paused && phase_items >= PHASE_ITEMS / 2) begin
					paused = 1'b1;
					in_valid <= 1'b0;
					do begin
						@(posedge clk);
					end while (sb.pending() != 0);
				end
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		$display("Sent %0d beats over %0d register settings; %0d query results checked,",
			beats_total, NUM_PHASES + 1, sb.checked);
		$display("%0d of them on solid blocks, with edge and interior faces mixed.",
			sb.solid_seen);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Hard stop if the handshakes ever hang.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles", cycle_count);
		$display("Mismatches found");
		$finish;
	end

endmodule : testbench
